// ===== hdl/rsr_pkg.sv =====
// ----------------------------------------------------------------------------
// rsr_pkg
// shared widths, state and mode codes and the control structs that pass
// between the row statistics core and its iterative divide / root unit
// ----------------------------------------------------------------------------
package rsr_pkg;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned MAX_ROW_LEN = 4096;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned SUM_W       = 29;
  localparam int unsigned SQSUM_W     = 43;
  localparam int unsigned SQ_SMP_W    = 31;
  localparam int unsigned MAG_W       = 28;
  localparam int unsigned MUL_W       = 28;
  localparam int unsigned PROD_W      = 2 * MUL_W;
  localparam int unsigned NUM_W       = 55;
  localparam int unsigned NN_W        = 25;
  localparam int unsigned OPND_W      = 64;
  localparam int unsigned REM_W       = 28;
  localparam int unsigned ROOT_W      = 24;
  localparam int unsigned STEP_W      = 7;

  localparam int unsigned ROW_SUM_W   = 28;
  localparam int unsigned MEAN_W      = 24;
  localparam int unsigned VAR_W       = 39;
  localparam int unsigned STD_W       = 24;

  // iteration counts: dividend bits consumed or root bits produced
  localparam logic [STEP_W-1:0] MEAN_STEPS = 7'd36;
  localparam logic [STEP_W-1:0] VAR_STEPS  = 7'd63;
  localparam logic [STEP_W-1:0] SQRT_STEPS = 7'd24;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MUL_SQ,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_NN,
    ST_DIV_MEAN,
    ST_DIV_VAR,
    ST_SQRT,
    ST_DONE
  } rsr_state_e;

  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } iter_mode_e;

  typedef struct packed {
    logic                start;
    iter_mode_e          mode;
    logic [STEP_W-1:0]   steps;
    logic [OPND_W-1:0]   operand;
    logic [NN_W-1:0]     divisor;
  } iter_req_t;

  typedef struct packed {
    logic                busy;
    logic [OPND_W-1:0]   result;
  } iter_status_t;

endpackage

// ===== hdl/rsr_iter_unit.sv =====
// ----------------------------------------------------------------------------
// rsr_iter_unit
// restoring divider and digit-by-digit square root sharing one
// compare-subtract; one quotient bit or one root bit per cycle
// ----------------------------------------------------------------------------
module rsr_iter_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rsr_pkg::iter_req_t   req_i,
  output rsr_pkg::iter_status_t status_o
);

  logic [rsr_pkg::STEP_W-1:0] cnt_q;
  rsr_pkg::iter_mode_e        mode_q;
  logic [rsr_pkg::OPND_W-1:0] dq_q;
  logic [rsr_pkg::REM_W-1:0]  rem_q;
  logic [rsr_pkg::ROOT_W-1:0] root_q;
  logic [rsr_pkg::NN_W-1:0]   div_q;

  logic [rsr_pkg::REM_W-1:0]  cmp_a;
  logic [rsr_pkg::REM_W-1:0]  cmp_b;
  logic [rsr_pkg::REM_W-1:0]  diff;
  logic                       ge;
  logic                       busy;

  assign busy = (cnt_q != '0);

  // shared compare-subtract
  always_comb begin
    if (mode_q == rsr_pkg::MODE_SQRT) begin
      cmp_a = {rem_q[rsr_pkg::REM_W-3:0], dq_q[rsr_pkg::OPND_W-1 -: 2]};
      cmp_b = {2'b00, root_q, 2'b01};
    end else begin
      cmp_a = {rem_q[rsr_pkg::REM_W-2:0], dq_q[rsr_pkg::OPND_W-1]};
      cmp_b = {3'b000, div_q};
    end
    ge   = (cmp_a >= cmp_b);
    diff = cmp_a - cmp_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      mode_q <= rsr_pkg::MODE_DIV;
    end else if (req_i.start) begin
      cnt_q  <= req_i.steps;
      mode_q <= req_i.mode;
    end else if (busy) begin
      cnt_q  <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q   <= req_i.operand;
      rem_q  <= '0;
      root_q <= '0;
      div_q  <= req_i.divisor;
    end else if (busy) begin
      rem_q <= ge ? diff : cmp_a;
      if (mode_q == rsr_pkg::MODE_SQRT) begin
        dq_q   <= {dq_q[rsr_pkg::OPND_W-3:0], 2'b00};
        root_q <= {root_q[rsr_pkg::ROOT_W-2:0], ge};
      end else begin
        dq_q   <= {dq_q[rsr_pkg::OPND_W-2:0], ge};
      end
    end
  end

  assign status_o.busy   = busy;
  assign status_o.result = (mode_q == rsr_pkg::MODE_SQRT)
                           ? {{(rsr_pkg::OPND_W-rsr_pkg::ROOT_W){1'b0}}, root_q}
                           : dq_q;

endmodule

// ===== hdl/row_statistics_reduction_core.sv =====
// ----------------------------------------------------------------------------
// row_statistics_reduction_core
// per-row max, min, sum, Q8 mean, Q8 population variance and Q8 deviation
// ----------------------------------------------------------------------------
// samples enter on the input channel (in_valid_i / in_stall_o / sample_i);
// every row_length words form one row and give one result word on the output
// channel (out_valid_o / out_stall_i and the row_* ports). row_length is
// written on the config channel (cfg_valid_i / cfg_ready_o) and clears any
// partial row; 0 acts as 1, values above 4096 as 4096. a config write offered
// together with a sample is taken first, the sample is stalled while cfg_valid_i is high.
// samples are accumulated one per cycle while the input is not stalled. after the
// last sample of a row the input stalls while the shared 28x28 multiplier
// forms |sum|^2, n*sumsq and n*n and the shared compare-subtract unit runs
// the mean divide, the variance divide and the square root; the results are
// then loaded into the result register.
// reset: row_length returns to 1, the accumulators clear, no result pending.
// stall: the result holds in the output register; a finished row waits
// until the previous result has been taken.
// ----------------------------------------------------------------------------
module row_statistics_reduction_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // sample channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             sample_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             row_max_o,
  output logic signed [15:0]             row_min_o,
  output logic signed [27:0]             row_sum_o,
  output logic signed [23:0]             row_mean_o,
  output logic        [38:0]             row_variance_o,
  output logic        [23:0]             row_std_o,
  // config channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic        [12:0]             cfg_row_length_i
);

  localparam int unsigned LW = rsr_pkg::LEN_W;

  rsr_pkg::rsr_state_e state_q, state_d;

  // accumulators
  logic [LW-1:0]                    len_q;
  logic [LW-1:0]                    count_q;
  logic signed [rsr_pkg::SAMPLE_W-1:0] max_q, min_q;
  logic signed [rsr_pkg::SUM_W-1:0]    sum_q;
  logic [rsr_pkg::SQSUM_W-1:0]         sqsum_q;

  // row-end intermediates
  logic [rsr_pkg::PROD_W-1:0]       sq_q;     // |sum|^2
  logic [rsr_pkg::PROD_W-1:0]       nsq_q;    // n * sumsq
  logic [rsr_pkg::MUL_W-1:0]        hi_q;     // n * sumsq upper part
  logic [rsr_pkg::NN_W-1:0]         nn_q;     // n * n
  logic [rsr_pkg::MEAN_W-1:0]       mean_q;
  logic [rsr_pkg::VAR_W-1:0]        var_q;
  logic [rsr_pkg::STD_W-1:0]        std_q;

  // output register
  logic                             out_valid_q;
  logic signed [15:0]               row_max_q, row_min_q;
  logic signed [27:0]               row_sum_q;
  logic signed [23:0]               row_mean_q;
  logic [38:0]                      row_var_q;
  logic [23:0]                      row_std_q;

  logic in_acc, cfg_acc, last, out_free;
  logic [LW-1:0] cfg_len;
  logic signed [31:0] smp_sq;
  logic [rsr_pkg::SUM_W-1:0] sum_neg;
  logic [rsr_pkg::MAG_W-1:0] mag;
  logic [rsr_pkg::MUL_W-1:0] mul_a, mul_b;
  logic [rsr_pkg::PROD_W-1:0] mul_p;
  logic [rsr_pkg::PROD_W-1:0] num;

  rsr_pkg::iter_req_t    iter_req;
  rsr_pkg::iter_status_t iter_st;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign last     = ((count_q + 1'b1) == len_q);
  assign out_free = !out_valid_q || !out_stall_i;

  // clamp written length into 1..max
  always_comb begin
    if (cfg_row_length_i == '0) begin
      cfg_len = LW'(1);
    end else if (cfg_row_length_i > LW'(rsr_pkg::MAX_ROW_LEN)) begin
      cfg_len = LW'(rsr_pkg::MAX_ROW_LEN);
    end else begin
      cfg_len = cfg_row_length_i;
    end
  end

  assign smp_sq  = sample_i * sample_i;
  assign sum_neg = -sum_q;
  assign mag     = sum_q[rsr_pkg::SUM_W-1] ? sum_neg[rsr_pkg::MAG_W-1:0]
                                           : sum_q[rsr_pkg::MAG_W-1:0];
  assign mul_p   = mul_a * mul_b;
  assign num     = nsq_q - sq_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rsr_pkg::ST_ACC:      if (in_acc && last && !cfg_acc) state_d = rsr_pkg::ST_MUL_SQ;
      rsr_pkg::ST_MUL_SQ:   state_d = rsr_pkg::ST_MUL_LO;
      rsr_pkg::ST_MUL_LO:   state_d = rsr_pkg::ST_MUL_HI;
      rsr_pkg::ST_MUL_HI:   state_d = rsr_pkg::ST_MUL_NN;
      rsr_pkg::ST_MUL_NN:   state_d = rsr_pkg::ST_DIV_MEAN;
      rsr_pkg::ST_DIV_MEAN: if (!iter_st.busy) state_d = rsr_pkg::ST_DIV_VAR;
      rsr_pkg::ST_DIV_VAR:  if (!iter_st.busy) state_d = rsr_pkg::ST_SQRT;
      rsr_pkg::ST_SQRT:     if (!iter_st.busy) state_d = rsr_pkg::ST_DONE;
      rsr_pkg::ST_DONE:     if (out_free) state_d = rsr_pkg::ST_ACC;
      default:              state_d = rsr_pkg::ST_ACC;
    endcase
  end

  // sequencer outputs: handshakes, multiplier operands, unit requests
  always_comb begin
    in_stall_o       = 1'b1;
    cfg_ready_o      = 1'b0;
    mul_a            = '0;
    mul_b            = '0;
    iter_req.start   = 1'b0;
    iter_req.mode    = rsr_pkg::MODE_DIV;
    iter_req.steps   = rsr_pkg::MEAN_STEPS;
    iter_req.operand = '0;
    iter_req.divisor = '0;
    unique case (state_q)
      rsr_pkg::ST_ACC: begin
        // a pending config write goes first
        in_stall_o  = cfg_valid_i;
        cfg_ready_o = 1'b1;
      end
      rsr_pkg::ST_MUL_SQ: begin
        mul_a = mag;
        mul_b = mag;
      end
      rsr_pkg::ST_MUL_LO: begin
        mul_a = {{(rsr_pkg::MUL_W-LW){1'b0}}, len_q};
        mul_b = sqsum_q[rsr_pkg::MUL_W-1:0];
      end
      rsr_pkg::ST_MUL_HI: begin
        mul_a = {{(rsr_pkg::MUL_W-LW){1'b0}}, len_q};
        mul_b = {{(2*rsr_pkg::MUL_W-rsr_pkg::SQSUM_W){1'b0}},
                 sqsum_q[rsr_pkg::SQSUM_W-1:rsr_pkg::MUL_W]};
      end
      rsr_pkg::ST_MUL_NN: begin
        mul_a = {{(rsr_pkg::MUL_W-LW){1'b0}}, len_q};
        mul_b = {{(rsr_pkg::MUL_W-LW){1'b0}}, len_q};
        // mean divide: (|sum| << 8) / n, left-aligned
        iter_req.start   = 1'b1;
        iter_req.mode    = rsr_pkg::MODE_DIV;
        iter_req.steps   = rsr_pkg::MEAN_STEPS;
        iter_req.operand = {mag, {rsr_pkg::FRAC_BITS{1'b0}}, {rsr_pkg::MAG_W{1'b0}}};
        iter_req.divisor = {{(rsr_pkg::NN_W-LW){1'b0}}, len_q};
      end
      rsr_pkg::ST_DIV_MEAN: begin
        // variance divide: ((n*sumsq - sum^2) << 8) / n^2
        iter_req.start   = !iter_st.busy;
        iter_req.mode    = rsr_pkg::MODE_DIV;
        iter_req.steps   = rsr_pkg::VAR_STEPS;
        iter_req.operand = {num[rsr_pkg::NUM_W-1:0], {rsr_pkg::FRAC_BITS{1'b0}}, 1'b0};
        iter_req.divisor = nn_q;
      end
      rsr_pkg::ST_DIV_VAR: begin
        // root of variance << 8, radicand padded to an even width
        iter_req.start   = !iter_st.busy;
        iter_req.mode    = rsr_pkg::MODE_SQRT;
        iter_req.steps   = rsr_pkg::SQRT_STEPS;
        iter_req.operand = {1'b0, iter_st.result[rsr_pkg::VAR_W-1:0],
                            {rsr_pkg::FRAC_BITS{1'b0}},
                            {(rsr_pkg::OPND_W-2*rsr_pkg::ROOT_W){1'b0}}};
      end
      rsr_pkg::ST_SQRT: begin
      end
      rsr_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  rsr_iter_unit u_iter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (iter_req),
    .status_o (iter_st)
  );

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rsr_pkg::ST_ACC;
      len_q       <= LW'(1);
      count_q     <= '0;
      max_q       <= {1'b1, {(rsr_pkg::SAMPLE_W-1){1'b0}}};
      min_q       <= {1'b0, {(rsr_pkg::SAMPLE_W-1){1'b1}}};
      sum_q       <= '0;
      sqsum_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_acc || (state_q == rsr_pkg::ST_DONE && out_free)) begin
        // new length or finished row: start a fresh row
        if (cfg_acc) len_q <= cfg_len;
        count_q <= '0;
        max_q   <= {1'b1, {(rsr_pkg::SAMPLE_W-1){1'b0}}};
        min_q   <= {1'b0, {(rsr_pkg::SAMPLE_W-1){1'b1}}};
        sum_q   <= '0;
        sqsum_q <= '0;
      end else if (in_acc) begin
        count_q <= count_q + 1'b1;
        if (sample_i > max_q) max_q <= sample_i;
        if (sample_i < min_q) min_q <= sample_i;
        sum_q   <= sum_q + rsr_pkg::SUM_W'(sample_i);
        sqsum_q <= sqsum_q + {{(rsr_pkg::SQSUM_W-rsr_pkg::SQ_SMP_W){1'b0}},
                              smp_sq[rsr_pkg::SQ_SMP_W-1:0]};
      end
      if (state_q == rsr_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // row-end datapath and result word
  always_ff @(posedge clk_i) begin
    case (state_q)
      rsr_pkg::ST_MUL_SQ: sq_q  <= mul_p;
      rsr_pkg::ST_MUL_LO: nsq_q <= mul_p;
      rsr_pkg::ST_MUL_HI: hi_q  <= mul_p[rsr_pkg::MUL_W-1:0];
      rsr_pkg::ST_MUL_NN: begin
        nn_q  <= mul_p[rsr_pkg::NN_W-1:0];
        nsq_q <= nsq_q + {hi_q, {rsr_pkg::MUL_W{1'b0}}};
      end
      rsr_pkg::ST_DIV_MEAN: if (!iter_st.busy) mean_q <= iter_st.result[rsr_pkg::MEAN_W-1:0];
      rsr_pkg::ST_DIV_VAR:  if (!iter_st.busy) var_q  <= iter_st.result[rsr_pkg::VAR_W-1:0];
      rsr_pkg::ST_SQRT:     if (!iter_st.busy) std_q  <= iter_st.result[rsr_pkg::STD_W-1:0];
      rsr_pkg::ST_DONE: begin
        if (out_free) begin
          row_max_q  <= max_q;
          row_min_q  <= min_q;
          row_sum_q  <= sum_q[rsr_pkg::ROW_SUM_W-1:0];
          // mean truncates toward zero: divide the magnitude, restore sign
          row_mean_q <= sum_q[rsr_pkg::SUM_W-1] ? -mean_q : mean_q;
          row_var_q  <= var_q;
          row_std_q  <= std_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign row_max_o      = row_max_q;
  assign row_min_o      = row_min_q;
  assign row_sum_o      = row_sum_q;
  assign row_mean_o     = row_mean_q;
  assign row_variance_o = row_var_q;
  assign row_std_o      = row_std_q;

endmodule
